// ===== design/iap_pkg.sv =====
package iap_pkg;

    // character classes seen by the parser core
    typedef enum logic [2:0] {
        K_DIGIT,
        K_HEX,
        K_DOT,
        K_SPACE,
        K_XCHAR,
        K_OTHER
    } tok_kind_t;

    typedef struct packed {
        logic      term;
        tok_kind_t kind;
        logic [3:0] val;
    } tok_t;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
        logic [2:0]  part_count;
    } res_t;

    localparam int TOK_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 2;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_SP   = 8'h20;

    localparam logic [31:0] MAX_8  = 32'h0000_00ff;
    localparam logic [31:0] MAX_16 = 32'h0000_ffff;
    localparam logic [31:0] MAX_24 = 32'h00ff_ffff;

endpackage

// ===== design/iap_fifo.sv =====
module iap_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    // DEPTH must be at least 2
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/iap_front.sv =====
module iap_front
    import iap_pkg::*;
(
    input  logic       push,
    input  logic [7:0] ch,
    output logic       full,
    input  logic       tok_full,
    output logic       tok_push,
    output tok_t       tok
);

    assign full     = tok_full;
    assign tok_push = push && !tok_full;

    // classify the character once so the core only sees a kind and a digit value
    always_comb
    begin
        tok.term = (ch == CH_NUL);
        tok.val  = ch[3:0];
        tok.kind = K_OTHER;
        if (ch inside {[8'h30:8'h39]})
        begin
            tok.kind = K_DIGIT;
        end
        else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            tok.kind = K_HEX;
            // 'a' and 'A' both have low nibble 1
            tok.val  = ch[3:0] + 4'd9;
        end
        else if (ch == CH_DOT)
        begin
            tok.kind = K_DOT;
        end
        else if (ch == CH_SP || (ch inside {[8'h09:8'h0d]}))
        begin
            tok.kind = K_SPACE;
        end
        else if (ch == CH_X_LO || ch == CH_X_UP)
        begin
            tok.kind = K_XCHAR;
        end
    end

endmodule

// ===== design/iap_back.sv =====
module iap_back
    import iap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok,
    input  logic tok_empty,
    output logic tok_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_TRAIL,
        PH_REJECT
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_OCT,
        RX_HEX
    } radix_t;

    phase_t      phase_reg, phase_next;
    radix_t      radix_reg, radix_next;
    logic [31:0] accum_reg, accum_next;
    logic        over_reg, over_next;
    logic [1:0]  parts_reg, parts_next;
    logic [7:0]  bytes_reg [3];
    logic [7:0]  bytes_next [3];

    radix_t      e_radix;
    logic [31:0] e_acc;
    logic        e_over;
    logic        do_dc;
    logic [35:0] prod;
    logic [2:0]  n;
    logic        ok;
    logic [31:0] addr;

    // a terminator waits until the result queue has room
    assign tok_pop  = !tok_empty && (!tok.term || !res_full);
    assign res_push = tok_pop && tok.term;

    always_comb
    begin
        case (e_radix)
            RX_HEX:  prod = {e_acc, 4'b0000};
            RX_OCT:  prod = {1'b0, e_acc, 3'b000};
            default: prod = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0};
        endcase
        prod = prod + {32'd0, tok.val};
    end

    always_comb
    begin
        n    = {1'b0, parts_reg} + 3'd1;
        ok   = (phase_reg != PH_REJECT) && !over_reg;
        addr = accum_reg;
        case (parts_reg)
            2'd1:
            begin
                ok   = ok && (accum_reg <= MAX_24);
                addr = accum_reg | {bytes_reg[0], 24'd0};
            end
            2'd2:
            begin
                ok   = ok && (accum_reg <= MAX_16);
                addr = accum_reg | {bytes_reg[0], bytes_reg[1], 16'd0};
            end
            2'd3:
            begin
                ok   = ok && (accum_reg <= MAX_8);
                addr = accum_reg | {bytes_reg[0], bytes_reg[1], bytes_reg[2], 8'd0};
            end
            default:
            begin
                addr = accum_reg;
            end
        endcase
        res.valid_res  = ok;
        res.address    = ok ? addr : 32'd0;
        res.part_count = n;
    end

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        accum_next = accum_reg;
        over_next  = over_reg;
        parts_next = parts_reg;
        bytes_next = bytes_reg;
        e_radix    = radix_reg;
        e_acc      = accum_reg;
        e_over     = over_reg;
        do_dc      = 1'b0;

        if (tok_pop)
        begin
            if (tok.term)
            begin
                // start a fresh string
                phase_next = PH_START;
                radix_next = RX_DEC;
                accum_next = '0;
                over_next  = 1'b0;
                parts_next = '0;
                bytes_next = '{default: 8'd0};
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        e_acc  = '0;
                        e_over = 1'b0;
                        if (tok.kind == K_DIGIT && tok.val == 4'd0)
                        begin
                            radix_next = RX_OCT;
                            phase_next = PH_ZERO;
                            accum_next = '0;
                            over_next  = 1'b0;
                        end
                        else
                        begin
                            e_radix = RX_DEC;
                            do_dc   = 1'b1;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (tok.kind == K_XCHAR)
                        begin
                            radix_next = RX_HEX;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            e_radix = RX_OCT;
                            do_dc   = 1'b1;
                        end
                    end
                    PH_DIGITS:
                    begin
                        do_dc = 1'b1;
                    end
                    default:
                    begin
                        // drop everything up to the terminator
                    end
                endcase

                if (do_dc)
                begin
                    radix_next = e_radix;
                    accum_next = e_acc;
                    over_next  = e_over;
                    if (tok.kind == K_DIGIT || (tok.kind == K_HEX && e_radix == RX_HEX))
                    begin
                        accum_next = prod[31:0];
                        over_next  = e_over | (|prod[35:32]);
                        phase_next = PH_DIGITS;
                    end
                    else if (tok.kind == K_DOT)
                    begin
                        if (parts_reg == 2'd3 || e_over || e_acc > MAX_8)
                        begin
                            phase_next = PH_REJECT;
                        end
                        else
                        begin
                            bytes_next[parts_reg] = e_acc[7:0];
                            parts_next = parts_reg + 2'd1;
                            accum_next = '0;
                            over_next  = 1'b0;
                            radix_next = RX_DEC;
                            phase_next = PH_START;
                        end
                    end
                    else if (tok.kind == K_SPACE)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        phase_next = PH_REJECT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            radix_reg <= RX_DEC;
            accum_reg <= '0;
            over_reg  <= 1'b0;
            parts_reg <= '0;
            bytes_reg <= '{default: 8'd0};
        end
        else
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            accum_reg <= accum_next;
            over_reg  <= over_next;
            parts_reg <= parts_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule

// ===== design/ipv4_dotted_address_parser.sv =====
// A terminator's result shows (empty low) after the character queue, then the result queue,
// both registered, when no character waits ahead of it. Throughput: one character per cycle
// while full is low; the parser core retires one queued character a cycle.
// A terminator stalls in the character queue only while the result queue is full.
// Reset (rst_n low, asynchronous) empties both queues and returns the parser to a new string.
module ipv4_dotted_address_parser
    import iap_pkg::*;
#(
    parameter int TOK_DEPTH = TOK_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    output logic        empty,
    input  logic        pop,
    output logic        valid_res,
    output logic [31:0] address,
    output logic [2:0]  part_count
);

    tok_t tok_in;
    tok_t tok_out;
    logic tok_push;
    logic tok_full;
    logic tok_empty;
    logic tok_pop;
    res_t res_in;
    res_t res_out;
    logic res_push;
    logic res_full;

    iap_front u_front (
        .push     (push),
        .ch       (ch),
        .full     (full),
        .tok_full (tok_full),
        .tok_push (tok_push),
        .tok      (tok_in)
    );

    iap_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .din   (tok_in),
        .full  (tok_full),
        .pop   (tok_pop),
        .dout  (tok_out),
        .empty (tok_empty)
    );

    iap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    iap_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign valid_res  = res_out.valid_res;
    assign address    = res_out.address;
    assign part_count = res_out.part_count;

endmodule

// ===== design/iap_checker.sv =====
module iap_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  ch,
    input logic        empty,
    input logic        pop,
    input logic        valid_res,
    input logic [31:0] address,
    input logic [2:0]  part_count
);

    // a waiting result beat stays until taken
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped before pop");

    a_stable_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(address) && $stable(valid_res) && $stable(part_count)))
        else $error("result beat changed while waiting");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !valid_res) |-> (address == 32'd0))
        else $error("rejected address is not zero");

    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (part_count != 3'd0 && part_count <= 3'd4))
        else $error("part count out of range");

    // an accepted input beat carries a known character
    a_known_char: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(ch))
        else $error("input beat accepted with unknown character");

endmodule

bind ipv4_dotted_address_parser iap_checker u_iap_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
    import iap_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_CHARS  = 1800;
    localparam int HOLD_CYCLES = 400;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [31:0] MAX_32  = 32'hffff_ffff;

    typedef enum logic [2:0] {
        ST_PART_START,
        ST_LEAD_ZERO,
        ST_DIGITS,
        ST_TAIL,
        ST_BAD
    } parse_phase_e;

    typedef enum logic [1:0] {
        RDX_DEC,
        RDX_OCT,
        RDX_HEX
    } radix_e;

    class addr_scoreboard;
        parse_phase_e phase;
        radix_e       radix;
        logic [31:0]  accum;
        logic         acc_over;
        logic [1:0]   parts_done;
        logic [7:0]   part_bytes[3];
        res_t         addr_q[$];
        int           errors;
        int           checked;
        int           accepted;

        function new();
            errors   = 0;
            checked  = 0;
            accepted = 0;
            clear();
        endfunction

        function void clear();
            phase      = ST_PART_START;
            radix      = RDX_DEC;
            accum      = '0;
            acc_over   = 1'b0;
            parts_done = '0;
            foreach (part_bytes[i])
                part_bytes[i] = '0;
        endfunction

        function int pending();
            return addr_q.size();
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void shift_digit(int unsigned base, logic [7:0] digit);
            logic [36:0] v;
            v = 37'(accum) * 37'(base) + 37'(digit);
            if (v[36:32] != '0)
                acc_over = 1'b1;
            accum = v[31:0];
        endfunction

        function void digit_char(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                shift_digit(radix == RDX_HEX ? 16 : (radix == RDX_OCT ? 8 : 10), c - CH_ZERO);
                phase = ST_DIGITS;
            end
            else if (radix == RDX_HEX && c >= CH_A_LO && c <= CH_F_LO)
            begin
                shift_digit(16, c - CH_A_LO + 8'd10);
                phase = ST_DIGITS;
            end
            else if (radix == RDX_HEX && c >= CH_A_UP && c <= CH_F_UP)
            begin
                shift_digit(16, c - CH_A_UP + 8'd10);
                phase = ST_DIGITS;
            end
            else if (c == CH_DOT)
            begin
                // a fourth dot or a dotted part above one byte kills the string
                if (parts_done == 2'd3 || acc_over || accum > MAX_8)
                    phase = ST_BAD;
                else
                begin
                    part_bytes[parts_done] = accum[7:0];
                    parts_done = parts_done + 2'd1;
                    accum      = '0;
                    acc_over   = 1'b0;
                    radix      = RDX_DEC;
                    phase      = ST_PART_START;
                end
            end
            else
                phase = is_space(c) ? ST_TAIL : ST_BAD;
        endfunction

        function void note_char(logic [7:0] c);
            res_t        r;
            logic [2:0]  n;
            logic        ok;
            logic [31:0] addr;
            if (c == CH_NUL)
            begin
                n    = {1'b0, parts_done} + 3'd1;
                ok   = phase != ST_BAD && !acc_over;
                addr = accum;
                if (ok)
                begin
                    case (n)
                        3'd2:
                        begin
                            ok   = accum <= MAX_24;
                            addr = addr | {part_bytes[0], 24'h0};
                        end
                        3'd3:
                        begin
                            ok   = accum <= MAX_16;
                            addr = addr | {part_bytes[0], part_bytes[1], 16'h0};
                        end
                        3'd4:
                        begin
                            ok   = accum <= MAX_8;
                            addr = addr | {part_bytes[0], part_bytes[1], part_bytes[2], 8'h0};
                        end
                        default: ;
                    endcase
                end
                r.valid_res  = ok;
                r.address    = ok ? addr : '0;
                r.part_count = n;
                addr_q.push_back(r);
                clear();
                return;
            end
            case (phase)
                ST_PART_START:
                begin
                    accum    = '0;
                    acc_over = 1'b0;
                    if (c == CH_ZERO)
                    begin
                        radix = RDX_OCT;
                        phase = ST_LEAD_ZERO;
                    end
                    else
                    begin
                        radix = RDX_DEC;
                        digit_char(c);
                    end
                end
                ST_LEAD_ZERO:
                begin
                    if (c == CH_X_LO || c == CH_X_UP)
                    begin
                        radix = RDX_HEX;
                        phase = ST_DIGITS;
                    end
                    else
                    begin
                        radix = RDX_OCT;
                        digit_char(c);
                    end
                end
                ST_DIGITS:
                    digit_char(c);
                default: ;
            endcase
        endfunction

        function void check_result(logic v, logic [31:0] a, logic [2:0] pc);
            res_t e;
            if (addr_q.size() == 0)
            begin
                $display("%0t: unexpected result beat: valid_res %0b address %h part_count %0d",
                         $time, v, a, pc);
                errors++;
                return;
            end
            e = addr_q.pop_front();
            checked++;
            if (e.valid_res)
                accepted++;
            if (v !== e.valid_res)
            begin
                $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                         $time, e.valid_res, v);
                errors++;
            end
            if (a !== e.address)
            begin
                $display("%0t: address mismatch: expected %h, actual %h",
                         $time, e.address, a);
                errors++;
            end
            if (pc !== e.part_count)
            begin
                $display("%0t: part_count mismatch: expected %0d, actual %0d",
                         $time, e.part_count, pc);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  ch = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        valid_res;
    logic [31:0] address;
    logic [2:0]  part_count;

    addr_scoreboard sb = new();
    logic [7:0]     str_q[$];
    int             chars_sent = 0;
    int             strings_sent = 0;
    int             cycle_cnt = 0;
    bit             calm = 1'b0;
    bit             hold_req = 1'b0;

    always #10 clk = ~clk;

    ipv4_dotted_address_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ch         (ch),
        .empty      (empty),
        .pop        (pop),
        .valid_res  (valid_res),
        .address    (address),
        .part_count (part_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_space();
        return ($urandom_range(0, 2) == 0) ? CH_SP : CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic void add_value(logic [32:0] v, radix_e r);
        logic [7:0]  digs[$];
        int unsigned base;
        logic [32:0] d;
        base = (r == RDX_HEX) ? 16 : ((r == RDX_OCT) ? 8 : 10);
        do
        begin
            d = v % base;
            if (d < 10)
                digs.push_front(CH_ZERO + 8'(d));
            else
                digs.push_front(($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(d - 10));
            v = v / base;
        end
        while (v != 0);
        if (r != RDX_DEC)
            str_q.push_back(CH_ZERO);
        if (r == RDX_HEX)
        begin
            str_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            if ($urandom_range(0, 3) == 0)
                str_q.push_back(CH_ZERO);
        end
        foreach (digs[i])
            str_q.push_back(digs[i]);
    endfunction

    function automatic void add_part(logic [31:0] lim);
        radix_e r;
        r = radix_e'($urandom_range(0, 2));
        case ($urandom_range(0, 15))
            0: ;
            1:
            begin
                str_q.push_back(CH_ZERO);
                str_q.push_back(CH_X_LO);
            end
            2:
                repeat ($urandom_range(10, 13))
                    str_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            3:
            begin
                // octal lead with 8 and 9 mixed in
                str_q.push_back(CH_ZERO);
                repeat ($urandom_range(1, 4))
                    str_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            4: add_value({1'b0, lim} + 33'd1, r);
            5: add_value({1'b0, lim}, r);
            6: add_value('0, r);
            7, 8: add_value(33'($urandom_range(0, 9)), r);
            default: add_value({1'b0, $urandom} % ({1'b0, lim} + 33'd1), r);
        endcase
    endfunction

    function automatic void gen_address();
        int          n;
        logic [31:0] lim;
        str_q.delete();
        n = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                str_q.push_back(CH_DOT);
            if (i < n - 1)
                lim = MAX_8;
            else
                case (n)
                    1: lim = MAX_32;
                    2: lim = MAX_24;
                    3: lim = MAX_16;
                    default: lim = MAX_8;
                endcase
            add_part(lim);
        end
        case ($urandom_range(0, 5))
            3: str_q.push_back(any_space());
            4:
            begin
                str_q.push_back(any_space());
                repeat ($urandom_range(1, 4))
                    str_q.push_back(8'($urandom_range(1, 255)));
            end
            5: str_q.push_back(8'($urandom_range(1, 255)));
            default: ;
        endcase
    endfunction

    function automatic void gen_noise();
        str_q.delete();
        repeat ($urandom_range(0, 10))
            case ($urandom_range(0, 7))
                0: str_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                1: str_q.push_back(CH_DOT);
                2: str_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                3: str_q.push_back(CH_A_LO + 8'($urandom_range(0, 6)));
                4: str_q.push_back(CH_A_UP + 8'($urandom_range(0, 6)));
                5: str_q.push_back(any_space());
                6: str_q.push_back(CH_ZERO);
                default: str_q.push_back(8'($urandom_range(1, 255)));
            endcase
    endfunction

    function automatic void load_text(string s);
        str_q.delete();
        for (int i = 0; i < s.len(); i++)
            str_q.push_back(s[i]);
    endfunction

    task automatic send_char(logic [7:0] c);
        int gap;
        @(negedge clk);
        push <= 1'b1;
        ch   <= c;
        do
            @(posedge clk);
        while (full);
        sb.note_char(c);
        chars_sent++;
        gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_string();
        foreach (str_q[i])
            send_char(str_q[i]);
        send_char(CH_NUL);
        strings_sent++;
    endtask

    task automatic send_text(string s);
        load_text(s);
        send_string();
    endtask

    // drop push first so no stray beat slips in while waiting
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(valid_res, address, part_count);
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, sb.pending());
        $display("ipv4_dotted_address_parser test failed");
        $finish;
    end

    initial
    begin : stimulus
        int dir_chars;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("");
        send_text("0");
        send_text("255.255.255.255");
        send_text("256.1");
        send_text("1.2.3.256");
        send_text("4294967295");
        send_text("4294967296");
        send_text("0x7f.0X1.0377.9");
        send_text("1.0xffffff");
        send_text("1.0x1000000");
        send_text("1.2.0XFFFF");
        send_text("0x");
        send_text("09");
        send_text("1..2");
        send_text("1.2.3.4.5");
        send_text("1 zz");
        send_text("1z");
        send_text("\t7");
        send_text("99999999999");
        load_text("1");
        str_q.push_back(8'hff);
        send_string();
        str_q.delete();
        str_q.push_back(8'h80);
        send_string();
        dir_chars = chars_sent;

        // hold input until everything has drained
        wait_drained();

        while (chars_sent < dir_chars + RAND_CHARS)
        begin
            if (strings_sent == 60)
                hold_req = 1'b1;
            if (strings_sent == 110)
                wait_drained();
            calm = strings_sent >= 150 && strings_sent < 180;
            case ($urandom_range(0, 9))
                7, 8: gen_noise();
                9: str_q.delete();
                default: gen_address();
            endcase
            send_string();
        end

        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("ran %0d strings (%0d characters) of dotted, octal, hex,", strings_sent,
                 chars_sent);
        $display("overflowing and junk input; checked %0d results, %0d of them accepted",
                 sb.checked, sb.accepted);
        if (sb.errors == 0)
            $display("ipv4_dotted_address_parser test passed");
        else
            $display("ipv4_dotted_address_parser test failed");
        $finish;
    end

endmodule
